### sv/assert_macros.svh
// assertion macros used by the checker file
// depends on a clk and an active-low rst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, off while in reset
`define SKT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// implication checked at the same edge
`define SKT_ASSERT_IMPL(lbl, ante, cons, msg) \
    `SKT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### sv/skt_pkg.sv
// shared types and codes for the sorted key table
// no dependencies
`default_nettype none

package skt_pkg;

    // operation codes on the command port
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result codes
    localparam logic [1:0] RES_DONE    = 2'd0;
    localparam logic [1:0] RES_DUP     = 2'd1;
    localparam logic [1:0] RES_MISSING = 2'd2;
    localparam logic [1:0] RES_FULL    = 2'd3;

    // width of the entry_count result field
    localparam int unsigned COUNT_BITS = 5;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch the transaction and the compare results against all valid cells
        logic do_insert;   // open a slot and write the new entry
        logic do_remove;   // close the matching slot
    } dp_ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic hit;         // key already held
        logic full;        // fill count at capacity
    } dp_stat_t;

endpackage

`default_nettype wire

### sv/skt_dpath.sv
// row of key/payload cells with parallel compare and one-place shift
// depends on skt_pkg
`default_nettype none

module skt_dpath #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned KEY_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire skt_pkg::dp_ctrl_t              ctrl,
    output skt_pkg::dp_stat_t                   stat,
    input  wire logic [15:0]                    key,
    input  wire logic [7:0]                     status_in,
    input  wire logic [31:0]                    counter_in,
    output logic [skt_pkg::COUNT_BITS-1:0]      entry_count
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // cell storage, meaningful only below the fill count
    logic [KEY_BITS-1:0] cell_key_reg  [CAPACITY];
    logic [7:0]          cell_stat_reg [CAPACITY];
    logic [31:0]         cell_pc_reg   [CAPACITY];

    // latched transaction
    logic [KEY_BITS-1:0] new_key_reg;
    logic [7:0]          new_stat_reg;
    logic [31:0]         new_pc_reg;

    // compare results: lt is a thermometer up to the sorted position
    logic [CAPACITY-1:0] lt_reg, lt_next;
    logic [CAPACITY-1:0] eq_vec;
    logic                hit_reg, hit_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;

    logic [31:0]         key_ext;
    logic [KEY_BITS-1:0] key_m;
    logic [31:0]         fill_ext;

    // key masked to the configured key width
    assign key_ext = 32'(key);
    assign key_m   = key_ext[KEY_BITS-1:0];

    // compare the incoming key against every valid cell
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cmp
            logic valid;
            assign valid      = CNT_W'(gi) < fill_reg;
            assign lt_next[gi] = valid && (cell_key_reg[gi] < key_m);
            assign eq_vec[gi]  = valid && (cell_key_reg[gi] == key_m);
        end
    endgenerate

    assign hit_next = |eq_vec;

    // compare stage and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg   <= '0;
            hit_reg  <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                lt_reg  <= lt_next;
                hit_reg <= hit_next;
            end
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.do_insert)
            fill_next = fill_reg + CNT_W'(1);
        else if (ctrl.do_remove)
            fill_next = fill_reg - CNT_W'(1);
    end

    // latched payload of the transaction
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            new_key_reg  <= key_m;
            new_stat_reg <= status_in;
            new_pc_reg   <= counter_in;
        end
    end

    // each cell keeps, takes its lower neighbor, the new entry, or its upper neighbor
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [KEY_BITS-1:0] key_next;
            logic [7:0]          stat_next;
            logic [31:0]         pc_next;
            logic                at_pos;

            if (gi == 0) begin : g_first
                assign at_pos = 1'b1;
            end
            else begin : g_rest
                assign at_pos = lt_reg[gi-1];
            end

            always_comb
            begin
                key_next  = cell_key_reg[gi];
                stat_next = cell_stat_reg[gi];
                pc_next   = cell_pc_reg[gi];
                if (ctrl.do_insert && !lt_reg[gi])
                begin
                    if (at_pos)
                    begin
                        key_next  = new_key_reg;
                        stat_next = new_stat_reg;
                        pc_next   = new_pc_reg;
                    end
                    else
                    begin
                        key_next  = cell_key_reg[(gi > 0) ? gi - 1 : 0];
                        stat_next = cell_stat_reg[(gi > 0) ? gi - 1 : 0];
                        pc_next   = cell_pc_reg[(gi > 0) ? gi - 1 : 0];
                    end
                end
                else if (ctrl.do_remove && !lt_reg[gi] && (gi < CAPACITY - 1))
                begin
                    key_next  = cell_key_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                    stat_next = cell_stat_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                    pc_next   = cell_pc_reg[(gi < CAPACITY - 1) ? gi + 1 : gi];
                end
            end

            always_ff @(posedge clk)
            begin
                cell_key_reg[gi]  <= key_next;
                cell_stat_reg[gi] <= stat_next;
                cell_pc_reg[gi]   <= pc_next;
            end
        end
    endgenerate

    // status and count toward the controller and the result port
    assign stat.hit  = hit_reg;
    assign stat.full = (fill_reg == CNT_W'(CAPACITY));

    assign fill_ext    = 32'(fill_reg);
    assign entry_count = fill_ext[skt_pkg::COUNT_BITS-1:0];

endmodule

`default_nettype wire

### sv/skt_ctrl.sv
// controller: accepts a transaction, decides the outcome, issues the shift
// depends on skt_pkg
`default_nettype none

module skt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              command,
    input  wire skt_pkg::dp_stat_t stat,
    output skt_pkg::dp_ctrl_t      ctrl,
    output logic                   busy,
    output logic                   done,
    output logic [1:0]             result_code
);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t     state_reg, state_next;
    logic       cmd_reg, cmd_next;
    logic       done_reg, done_next;
    logic [1:0] code_reg, code_next;

    // next state, outcome and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        done_next      = 1'b0;
        code_next      = code_reg;
        ctrl           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    cmd_next     = command;
                    state_next   = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (cmd_reg == skt_pkg::CMD_INSERT)
                begin
                    if (stat.hit)
                        code_next = skt_pkg::RES_DUP;
                    else if (stat.full)
                        code_next = skt_pkg::RES_FULL;
                    else
                    begin
                        code_next      = skt_pkg::RES_DONE;
                        ctrl.do_insert = 1'b1;
                    end
                end
                else
                begin
                    if (stat.hit)
                    begin
                        code_next      = skt_pkg::RES_DONE;
                        ctrl.do_remove = 1'b1;
                    end
                    else
                        code_next = skt_pkg::RES_MISSING;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= skt_pkg::CMD_INSERT;
            done_reg  <= 1'b0;
            code_reg  <= skt_pkg::RES_DONE;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            done_reg  <= done_next;
            code_reg  <= code_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result_code = code_reg;

endmodule

`default_nettype wire

### sv/sorted_key_table_core.sv
// Sorted key table: up to CAPACITY entries kept in ascending key order.
// Result strobe (done) is registered from the update state entered on the start transaction.
// A new transaction is taken only once the compare step of the cell row and its
// one-place shift step are through (busy is high meanwhile); the receiver cannot stall.
// Reset: asynchronous active low, empties the table (count 0), no clearing pass.
// depends on skt_pkg, skt_ctrl, skt_dpath
`default_nettype none

module sorted_key_table_core #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned KEY_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [15:0] key,
    input  wire logic [7:0]  status_in,
    input  wire logic [31:0] counter_in,
    output logic             done,
    output logic [1:0]       result_code,
    output logic [4:0]       entry_count
);

    skt_pkg::dp_ctrl_t ctrl;
    skt_pkg::dp_stat_t stat;

    // controller
    skt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .stat        (stat),
        .ctrl        (ctrl),
        .busy        (busy),
        .done        (done),
        .result_code (result_code)
    );

    // cell row datapath
    skt_dpath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .key         (key),
        .status_in   (status_in),
        .counter_in  (counter_in),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire

### sv/skt_checker.sv
// port-level checks for sorted_key_table_core, attached by bind
// depends on skt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module skt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        command,
    input wire logic [15:0] key,
    input wire logic [7:0]  status_in,
    input wire logic [31:0] counter_in,
    input wire logic        done,
    input wire logic [1:0]  result_code,
    input wire logic [4:0]  entry_count
);

    logic accept;
    logic unused_payload;

    assign accept         = start && !busy;
    assign unused_payload = command ^ (^key) ^ (^status_in) ^ (^counter_in);

    // an accepted transaction raises busy, holding off the next one
    `SKT_ASSERT(a_accept_busy, accept |=> busy, "busy not raised after accept")

    // every accepted transaction gets a result strobe
    `SKT_ASSERT(a_result_lat, accept |=> ##1 done, "result strobe missing")

    // the result strobe lasts a single cycle
    `SKT_ASSERT(a_strobe_pulse, done |=> !done, "result strobe held")

    // a result shows while the block is free for the next transaction
    `SKT_ASSERT_IMPL(a_done_idle, done, !busy, "busy during result strobe")

    // a rejected transaction leaves the count unchanged
    `SKT_ASSERT_IMPL(a_reject_count, done && (result_code != skt_pkg::RES_DONE),
        entry_count == $past(entry_count), "count moved on rejected transaction")

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (.*);

`default_nettype wire
